// ===== rtl/segment_intersection_unit_assert.svh =====
// Assertion macros shared by the segment intersection RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define SIU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/siu_pkg.sv =====
// Package for the segment intersection unit.
// Holds the default coordinate width; depends on nothing.
package siu_pkg;

    localparam int COORD_BITS_DEF = 16;

endpackage

// ===== rtl/segment_intersection_unit.sv =====
// Segment intersection unit: exact 3D segment-segment test, fully pipelined.
// Depends on siu_pkg and segment_intersection_unit_assert.svh.
//
// Takes two segments A1-A2 and B1-B2 (signed COORD_BITS coordinates) per input
// beat and returns one result beat: hit in tuser, intersection point in tdata
// (zero when no hit). An x-y bounding-box reject comes first, then
// n = V2 x V1, den = n.n, unum = (d x V2).n, vnum = (d x V1).n are formed
// exactly; a hit needs den != 0 and 0 <= unum, vnum <= den, and the point is
// A1 + trunc(unum * V1 / den). One beat enters per cycle unless the output
// side stalls; the depth is set by the restoring divider, which resolves one
// quotient bit per stage. The whole pipeline holds while a finished result
// waits and the output side is not ready.
`include "segment_intersection_unit_assert.svh"

module segment_intersection_unit
    import siu_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_DW      = ((12 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DW     = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // a1_x, a1_y, a1_z, a2_x, a2_y, a2_z, b1_x, b1_y, b1_z, b2_x, b2_y, b2_z
    input  logic [IN_DW-1:0]  i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // cross_x, cross_y, cross_z
    output logic [OUT_DW-1:0] o_m_tdata,
    // hit
    output logic [0:0]        o_m_tuser
);

    localparam int CW  = COORD_BITS;
    localparam int VW  = CW + 1;             // edge and offset vectors
    localparam int PW  = 2 * VW;             // products of vector components
    localparam int NW  = PW + 1;             // cross-product components
    localparam int H   = (NW + 1) / 2;       // low half of a split operand
    localparam int HH  = NW - H;             // signed high half
    localparam int PPW = 2 * H + 2;          // partial product width
    localparam int DW  = 2 * NW + 2;         // dot products
    localparam int UW  = DW - 1;             // nonnegative numerator / den
    localparam int KC  = CW;                 // chunk of the numerator
    localparam int NC  = (UW + KC - 1) / KC; // chunk count
    localparam int EW  = (NC + 1) * KC;
    localparam int NDW = UW + CW;            // dividend width
    localparam int QB  = CW;                 // quotient bits
    localparam int S_CHK = 6;
    localparam int S_DVD = 7;
    localparam int NST   = QB + 9;

    typedef struct packed {
        logic                 ok;
        logic [2:0]           neg;
        logic [2:0][CW-1:0]   a1;
        logic [2:0][CW-1:0]   mag;
    } t_side;

    logic             w_en;
    logic             w_chk;
    logic [NST-1:0]   r_vld;
    t_side            r_side [NST];
    t_side            n_side;

    // Global advance: everything moves unless a result waits unread.
    assign w_en       = !r_vld[NST-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: unpack, box reject, edge vectors
    // ---------------------------------------------------------------
    logic signed [CW-1:0] w_c [12];
    logic signed [VW-1:0] n_v1 [3];
    logic signed [VW-1:0] n_v2 [3];
    logic signed [VW-1:0] n_d  [3];
    logic signed [VW-1:0] r_v1 [3];
    logic signed [VW-1:0] r_v2 [3];
    logic signed [VW-1:0] r_d  [3];

    always_comb begin
        logic signed [CW-1:0] axl, axh, ayl, ayh, bxl, bxh, byl, byh;
        for (int i = 0; i < 12; i++) begin
            w_c[i] = $signed(i_s_tdata[i*CW +: CW]);
        end
        axl = (w_c[0] < w_c[3]) ? w_c[0] : w_c[3];
        axh = (w_c[0] < w_c[3]) ? w_c[3] : w_c[0];
        ayl = (w_c[1] < w_c[4]) ? w_c[1] : w_c[4];
        ayh = (w_c[1] < w_c[4]) ? w_c[4] : w_c[1];
        bxl = (w_c[6] < w_c[9]) ? w_c[6] : w_c[9];
        bxh = (w_c[6] < w_c[9]) ? w_c[9] : w_c[6];
        byl = (w_c[7] < w_c[10]) ? w_c[7] : w_c[10];
        byh = (w_c[7] < w_c[10]) ? w_c[10] : w_c[7];
        n_side.ok = !(axh < bxl || axl > bxh || ayh < byl || ayl > byh);
        for (int k = 0; k < 3; k++) begin
            n_v1[k] = VW'(w_c[3+k]) - VW'(w_c[k]);
            n_v2[k] = VW'(w_c[9+k]) - VW'(w_c[6+k]);
            n_d[k]  = VW'(w_c[k]) - VW'(w_c[6+k]);
            n_side.neg[k] = n_v1[k][VW-1];
            n_side.mag[k] = n_v1[k][VW-1] ? CW'(-n_v1[k]) : CW'(n_v1[k]);
            n_side.a1[k]  = w_c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_d  <= n_d;
            r_side[0] <= n_side;
            for (int s = 1; s < NST; s++) begin
                if (s != S_CHK) begin
                    r_side[s] <= r_side[s-1];
                end
            end
            r_side[S_CHK] <= '{ok:  r_side[S_CHK-1].ok && w_chk,
                               neg: r_side[S_CHK-1].neg,
                               a1:  r_side[S_CHK-1].a1,
                               mag: r_side[S_CHK-1].mag};
        end
    end

    // ---------------------------------------------------------------
    // Stages 1-2: cross products n = v2 x v1, cu = d x v2, cv = d x v1
    // ---------------------------------------------------------------
    logic signed [PW-1:0] r_pa [3][3];
    logic signed [PW-1:0] r_pb [3][3];
    logic signed [NW-1:0] r_cr [3][3];

    for (genvar k = 0; k < 3; k++) begin : g_cross
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pa[0][k] <= PW'(r_v2[K1]) * PW'(r_v1[K2]);
                r_pb[0][k] <= PW'(r_v2[K2]) * PW'(r_v1[K1]);
                r_pa[1][k] <= PW'(r_d[K1]) * PW'(r_v2[K2]);
                r_pb[1][k] <= PW'(r_d[K2]) * PW'(r_v2[K1]);
                r_pa[2][k] <= PW'(r_d[K1]) * PW'(r_v1[K2]);
                r_pb[2][k] <= PW'(r_d[K2]) * PW'(r_v1[K1]);
                r_cr[0][k] <= NW'(r_pa[0][k]) - NW'(r_pb[0][k]);
                r_cr[1][k] <= NW'(r_pa[1][k]) - NW'(r_pb[1][k]);
                r_cr[2][k] <= NW'(r_pa[2][k]) - NW'(r_pb[2][k]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 3-5: dot products with n, split into half-width partials
    // ---------------------------------------------------------------
    logic signed [PPW-1:0] r_pp  [3][3][4];
    logic signed [DW-1:0]  r_prd [3][3];
    logic signed [DW-1:0]  r_dot [3];   // den, unum, vnum

    always_ff @(posedge i_clk) begin
        logic signed [H:0]    xl, yl;
        logic signed [HH-1:0] xh, yh;
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    xl = $signed({1'b0, r_cr[j][k][H-1:0]});
                    xh = $signed(r_cr[j][k][NW-1:H]);
                    yl = $signed({1'b0, r_cr[0][k][H-1:0]});
                    yh = $signed(r_cr[0][k][NW-1:H]);
                    r_pp[j][k][0] <= PPW'(xl) * PPW'(yl);
                    r_pp[j][k][1] <= PPW'(xl) * PPW'(yh);
                    r_pp[j][k][2] <= PPW'(xh) * PPW'(yl);
                    r_pp[j][k][3] <= PPW'(xh) * PPW'(yh);
                    r_prd[j][k] <= (DW'(r_pp[j][k][3]) <<< (2 * H))
                                 + ((DW'(r_pp[j][k][1]) + DW'(r_pp[j][k][2])) <<< H)
                                 + DW'(r_pp[j][k][0]);
                end
                r_dot[j] <= r_prd[j][0] + r_prd[j][1] + r_prd[j][2];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: range check, numerator times |V1| in chunks
    // Stage 7: recombine into the dividend (even and odd chunks)
    // ---------------------------------------------------------------
    logic [NC*KC-1:0]     w_um;
    logic [2*KC-1:0]      r_up [3][NC];
    logic [UW-1:0]        r_den6;

    assign w_chk = (r_dot[0] != '0) && !r_dot[1][DW-1] && !r_dot[2][DW-1]
                && (r_dot[1] <= r_dot[0]) && (r_dot[2] <= r_dot[0]);
    assign w_um  = (NC*KC)'(r_dot[1][UW-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den6 <= r_dot[0][UW-1:0];
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < NC; c++) begin
                    r_up[k][c] <= (2*KC)'(w_um[c*KC +: KC])
                                * (2*KC)'(r_side[S_CHK-1].mag[k]);
                end
            end
        end
    end

    logic [NDW-1:0] r_rem  [QB+1][3];
    logic [QB-1:0]  r_q    [QB+1][3];
    logic [UW-1:0]  r_dden [QB+1];

    always_ff @(posedge i_clk) begin
        logic [EW-1:0] ev, od, sm;
        if (w_en) begin
            r_dden[0] <= r_den6;
            for (int k = 0; k < 3; k++) begin
                ev = '0;
                od = '0;
                for (int c = 0; c < NC; c++) begin
                    if (c % 2 == 0) begin
                        ev[c*KC +: 2*KC] = r_up[k][c];
                    end else begin
                        od[c*KC +: 2*KC] = r_up[k][c];
                    end
                end
                sm = ev + od;
                r_rem[0][k] <= sm[NDW-1:0];
                r_q[0][k]   <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Restoring divider: one quotient bit per stage, MSB first
    // ---------------------------------------------------------------
    for (genvar i = 0; i < QB; i++) begin : g_div
        localparam int B = QB - 1 - i;
        always_ff @(posedge i_clk) begin
            logic [NDW-1:0] sh;
            if (w_en) begin
                sh = NDW'(r_dden[i]) << B;
                r_dden[i+1] <= r_dden[i];
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[i][k] >= sh) begin
                        r_rem[i+1][k]  <= r_rem[i][k] - sh;
                        r_q[i+1][k]    <= r_q[i][k] | (QB'(1) << B);
                    end else begin
                        r_rem[i+1][k]  <= r_rem[i][k];
                        r_q[i+1][k]    <= r_q[i][k];
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: P = A1 +/- q, zero on a miss
    // ---------------------------------------------------------------
    logic [CW-1:0] r_px [3];

    always_ff @(posedge i_clk) begin
        logic signed [CW:0] qs, ps;
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                qs = $signed({1'b0, r_q[QB][k]});
                ps = r_side[NST-2].neg[k] ? ((CW+1)'($signed(r_side[NST-2].a1[k])) - qs)
                                          : ((CW+1)'($signed(r_side[NST-2].a1[k])) + qs);
                r_px[k] <= r_side[NST-2].ok ? ps[CW-1:0] : '0;
            end
        end
    end

    assign o_m_tdata = OUT_DW'({r_px[2], r_px[1], r_px[0]});
    assign o_m_tuser = r_side[NST-1].ok;

    `SIU_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0)
    `SIU_ASSERT_IMPL(a_stall_holds, i_clk, i_rst_n, r_vld[NST-1] && !i_m_tready, !o_s_tready)
    `SIU_ASSERT_NEXT(a_beat_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld[0])
    `SIU_ASSERT_IMPL(a_hit_den, i_clk, i_rst_n, r_vld[S_DVD] && r_side[S_DVD].ok, r_dden[0] != '0)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for segment_intersection_unit.
// Depends on siu_pkg and the RTL; streams segment pairs, predicts each answer
// with exact wide arithmetic and checks every result beat in order.
module tb_top;
    import siu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB     = COORD_BITS_DEF;
    localparam int IN_DW  = ((12 * CB + 7) / 8) * 8;
    localparam int OUT_DW = ((3 * CB + 7) / 8) * 8;
    localparam int LATENCY = CB + 9;
    localparam int N_RANDOM = 630;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [CB-1:0] coord_t;
    typedef coord_t seg_pair_t[12];   // a1 xyz, a2 xyz, b1 xyz, b2 xyz
    typedef longint vec3_t[3];
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic   hit;
        coord_t px;
        coord_t py;
        coord_t pz;
    } crossing_t;

    // Exact geometry for one segment pair.
    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic wide_t dot3(vec3_t a, vec3_t b);
        wide_t s;
        s = 0;
        for (int k = 0; k < 3; k++) s += wide_t'(a[k]) * wide_t'(b[k]);
        return s;
    endfunction

    function automatic crossing_t find_crossing(seg_pair_t c);
        vec3_t a1, a2, b1, b2, v1, v2, dd, nrm;
        wide_t den, unum, vnum, q;
        longint p;
        crossing_t r;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            a1[k] = c[k]; a2[k] = c[3+k]; b1[k] = c[6+k]; b2[k] = c[9+k];
        end
        // x-y box reject, z ignored
        for (int k = 0; k < 2; k++) begin
            if ((a1[k] > a2[k] ? a1[k] : a2[k]) < (b1[k] < b2[k] ? b1[k] : b2[k]) ||
                (a1[k] < a2[k] ? a1[k] : a2[k]) > (b1[k] > b2[k] ? b1[k] : b2[k]))
                return r;
        end
        for (int k = 0; k < 3; k++) begin
            v1[k] = a2[k] - a1[k];
            v2[k] = b2[k] - b1[k];
            dd[k] = a1[k] - b1[k];
        end
        nrm  = cross3(v2, v1);
        den  = dot3(nrm, nrm);
        unum = dot3(cross3(dd, v2), nrm);
        vnum = dot3(cross3(dd, v1), nrm);
        if (den == 0 || unum < 0 || vnum < 0 || unum > den || vnum > den) return r;
        r.hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            q = (unum * wide_t'(v1[k] < 0 ? -v1[k] : v1[k])) / den;
            p = v1[k] < 0 ? a1[k] - longint'(q) : a1[k] + longint'(q);
            if (k == 0) r.px = coord_t'(p);
            else if (k == 1) r.py = coord_t'(p);
            else r.pz = coord_t'(p);
        end
        return r;
    endfunction

    class crossing_board;
        crossing_t pending[$];
        int errors;

        function void note_pair(seg_pair_t c);
            pending.push_back(find_crossing(c));
        endfunction

        function void check_result(crossing_t got);
            crossing_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected hit=%0d p=(%0d,%0d,%0d)",
                              " got hit=%0d p=(%0d,%0d,%0d)"},
                             want.hit, want.px, want.py, want.pz,
                             got.hit, got.px, got.py, got.pz);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_DW-1:0]  i_s_tdata = '0;   // a1_x .. b2_z, 16 bits each, a1_x lowest
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_DW-1:0] o_m_tdata;        // cross_x, cross_y, cross_z from bit 0 up
    logic [0:0]        o_m_tuser;        // hit

    crossing_board board = new();
    int  n_sent = 0;
    bit  calm = 1'b0;     // last stretch: no idling on either side
    int  cycles = 0;

    always #6 i_clk = ~i_clk;

    segment_intersection_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    // Watchdog: give up if the run stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check every output beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result({o_m_tuser[0], o_m_tdata[0 +: CB],
                                o_m_tdata[CB +: CB], o_m_tdata[2*CB +: CB]});
    end

    // Output side: hold off once for a long stretch to back up the pipeline,
    // then stall in random bursts until the calm phase.
    initial begin
        @(posedge i_clk iff i_rst_n);
        i_m_tready <= 1'b1;
        wait (n_sent >= 40);
        @(posedge i_clk);
        i_m_tready <= 1'b0;
        repeat (300) @(posedge i_clk);
        while (!calm) begin
            i_m_tready <= $urandom_range(0, 2) != 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_m_tready <= 1'b1;
    end

    // Offer one pair and wait for the handshake; call right after posedge i_clk.
    task automatic send_pair(seg_pair_t c);
        logic [IN_DW-1:0] bus;
        bus = '0;
        for (int k = 0; k < 12; k++) bus[CB*k +: CB] = c[k];
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= bus;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_pair(c);
        n_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send_pts(int a1x, int a1y, int a1z, int a2x, int a2y, int a2z,
                            int b1x, int b1y, int b1z, int b2x, int b2y, int b2z);
        seg_pair_t c;
        c = '{coord_t'(a1x), coord_t'(a1y), coord_t'(a1z), coord_t'(a2x), coord_t'(a2y),
              coord_t'(a2z), coord_t'(b1x), coord_t'(b1y), coord_t'(b1z), coord_t'(b2x),
              coord_t'(b2y), coord_t'(b2z)};
        send_pair(c);
    endtask

    // Two segments through a common point P, each along its own direction.
    task automatic send_meeting_pair();
        int p[3], wa[3], wb[3], ka1, ka2, kb1, kb2;
        seg_pair_t c;
        ka1 = $urandom_range(0, 15); ka2 = $urandom_range(0, 15);
        kb1 = $urandom_range(0, 15); kb2 = $urandom_range(0, 15);
        for (int k = 0; k < 3; k++) begin
            p[k]  = $urandom_range(0, 32000) - 16000;
            wa[k] = $urandom_range(0, 1000) - 500;
            wb[k] = $urandom_range(0, 1000) - 500;
            c[k]   = coord_t'(p[k] - ka1 * wa[k]);
            c[3+k] = coord_t'(p[k] + ka2 * wa[k]);
            c[6+k] = coord_t'(p[k] - kb1 * wb[k]);
            c[9+k] = coord_t'(p[k] + kb2 * wb[k]);
        end
        send_pair(c);
    endtask

    initial begin
        seg_pair_t c;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Crossing in the x-y plane, a clean hit.
        send_pts(-10, 0, 0, 10, 0, 0, 0, -10, 0, 0, 10, 0);
        // Hit exactly at end points (u = 0 and v = 1).
        send_pts(0, 0, 0, 8, 8, 8, -4, 4, 0, 0, 0, 0);
        // Disjoint boxes.
        send_pts(0, 0, 0, 5, 5, 0, 10, 10, 0, 20, 20, 0);
        // Boxes overlap in x-y, disjoint in z only: test goes on.
        send_pts(0, 0, 100, 10, 10, 100, 0, 10, -100, 10, 0, -100);
        // Parallel segments.
        send_pts(0, 0, 0, 10, 10, 0, 0, 1, 0, 10, 11, 0);
        // Collinear overlapping segments.
        send_pts(0, 0, 0, 10, 10, 10, 5, 5, 5, 15, 15, 15);
        // Degenerate point segment.
        send_pts(3, 3, 3, 3, 3, 3, 0, 0, 0, 6, 6, 6);
        // Lines meet beyond the end of A, but the x-y boxes are already disjoint.
        send_pts(0, 0, 0, 4, 0, 0, 8, -5, 0, 8, 5, 0);
        // Lines meet before the start of B, but the x-y boxes are already disjoint.
        send_pts(-10, 0, 0, 10, 0, 0, 0, 2, 0, 0, 10, 0);
        // Segments tilted in z that still meet at the origin, boxes overlapping.
        send_pts(-10, 0, 0, 10, 0, 0, 0, -10, 5, 0, 10, -5);
        // Extremes of the coordinate range.
        send_pts(-32768, -32768, -32768, 32767, 32767, 32767,
                 -32768, 32767, 32767, 32767, -32768, -32768);
        send_pts(32767, -32768, 0, -32768, 32767, 0,
                 -32768, -32768, -32768, 32767, 32767, 32767);
        send_pts(-32768, 0, 32767, 32767, 0, -32768, 0, -32768, -32768, 0, 32767, 32767);
        send_pts(32767, 32767, 32767, 32767, 32767, 32767,
                 32767, 32767, 32767, 32767, 32767, 32767);
        send_pts(-32768, -32768, -32768, -32768, -32768, -32768,
                 32767, 32767, 32767, -32768, -32768, -32768);
        // Truncation of a negative direction toward A1.
        send_pts(10, 10, 10, -10, -11, -7, -10, 10, 0, 10, -11, 1);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 80) calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (int k = 0; k < 12; k++) c[k] = coord_t'($urandom());
                    send_pair(c);
                end
                2: begin
                    // small box, mixed outcomes
                    for (int k = 0; k < 12; k++) c[k] = coord_t'($urandom_range(0, 40) - 20);
                    send_pair(c);
                end
                default: send_meeting_pair();
            endcase
        end
        i_s_tvalid <= 1'b0;

        calm = 1'b1;
        wait (board.pending.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
